@@ sv/lgs_pkg.sv @@
// Shared types, widths and codes for the LDA Gibbs topic sampler.
// No dependencies; every other file but lgs_div uses this package.
package lgs_pkg;

  localparam int MAX_TOPICS = 64;
  localparam int MAX_VOCAB  = 1024;

  localparam int TOPIC_W = $clog2(MAX_TOPICS);
  localparam int WORD_W  = $clog2(MAX_VOCAB);
  localparam int KCNT_W  = $clog2(MAX_TOPICS + 1);
  localparam int WTC_AW  = WORD_W + TOPIC_W;

  localparam int OPC_W   = 3;
  localparam int IN_TW   = 6;
  localparam int IN_WW   = 10;
  localparam int COUNT_W = 31;
  localparam int TOT_W   = 48;
  localparam int Q_W     = 32;
  localparam int TCFG_W  = 7;
  localparam int VCFG_W  = 11;
  localparam int CIDX_W  = 3;

  localparam logic [COUNT_W-1:0] COUNT_CEILING = 31'd2000000000;
  localparam logic [COUNT_W-1:0] MAX31 = '1;
  localparam logic [TOT_W-1:0]   MAX48 = '1;

  // input opcodes
  localparam logic [OPC_W-1:0] OP_LOAD_MODEL = 3'd0;
  localparam logic [OPC_W-1:0] OP_LOAD_DOC   = 3'd1;
  localparam logic [OPC_W-1:0] OP_SAMPLE     = 3'd2;
  localparam logic [OPC_W-1:0] OP_READ_DOC   = 3'd3;
  localparam logic [OPC_W-1:0] OP_READ_MODEL = 3'd4;

  // classified command kinds
  localparam logic [2:0] CK_NOP        = 3'd0;
  localparam logic [2:0] CK_ERR        = 3'd1;
  localparam logic [2:0] CK_LOAD_MODEL = 3'd2;
  localparam logic [2:0] CK_LOAD_DOC   = 3'd3;
  localparam logic [2:0] CK_SAMPLE     = 3'd4;
  localparam logic [2:0] CK_READ_DOC   = 3'd5;
  localparam logic [2:0] CK_READ_MODEL = 3'd6;

  // configuration register indexes
  localparam logic [CIDX_W-1:0] CFG_ALPHA  = 3'd0;
  localparam logic [CIDX_W-1:0] CFG_BETA   = 3'd1;
  localparam logic [CIDX_W-1:0] CFG_TOPICS = 3'd2;
  localparam logic [CIDX_W-1:0] CFG_VOCAB  = 3'd3;
  localparam logic [CIDX_W-1:0] CFG_TRAIN  = 3'd4;

  typedef struct packed {
    logic [2:0]         kind;
    logic [WORD_W-1:0]  word;
    logic [TOPIC_W-1:0] topic;
    logic [COUNT_W-1:0] value;
    logic [Q_W-1:0]     rnd;
    logic [KCNT_W-1:0]  kact;
  } cmd_t;

  typedef struct packed {
    logic [IN_TW-1:0]   new_topic;
    logic [COUNT_W-1:0] read_value;
    logic               ceiling_hit;
    logic               status;
  } res_t;

  typedef struct packed {
    logic [Q_W-1:0] alpha;
    logic [Q_W-1:0] beta;
    logic           train;
  } cfg_t;

endpackage

@@ sv/lgs_front.sv @@
// Front end: configuration registers, input acceptance and classification.
// Depends on lgs_pkg; feeds lgs_cmd_q.
module lgs_front (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [lgs_pkg::CIDX_W-1:0]  cfg_index,
  input  logic [lgs_pkg::Q_W-1:0]     cfg_wdata,
  input  logic                        in_push,
  input  logic [lgs_pkg::OPC_W-1:0]   in_opcode,
  input  logic [lgs_pkg::IN_WW-1:0]   in_word_id,
  input  logic [lgs_pkg::IN_TW-1:0]   in_topic_in,
  input  logic [lgs_pkg::COUNT_W-1:0] in_load_value,
  input  logic [lgs_pkg::Q_W-1:0]     in_random_frac,
  input  logic                        q_full,
  input  logic                        clearing,
  output logic                        in_full,
  output logic                        cmd_push,
  output lgs_pkg::cmd_t               cmd,
  output lgs_pkg::cfg_t               cfg
);
  import lgs_pkg::*;

  logic [Q_W-1:0]    alpha_r, beta_r;
  logic [TCFG_W-1:0] tcount_r;
  logic [VCFG_W-1:0] vcount_r;
  logic              train_r;
  logic [KCNT_W-1:0] kact;
  logic [VCFG_W:0]   vact;
  logic              uses_word, bad_idx;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alpha_r  <= 32'd65536;
      beta_r   <= 32'd65536;
      tcount_r <= 7'd64;
      vcount_r <= 11'd1024;
      train_r  <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ALPHA:  alpha_r  <= cfg_wdata;
        CFG_BETA:   beta_r   <= cfg_wdata;
        CFG_TOPICS: tcount_r <= cfg_wdata[TCFG_W-1:0];
        CFG_VOCAB:  vcount_r <= cfg_wdata[VCFG_W-1:0];
        CFG_TRAIN:  train_r  <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // clamp the active topic and word counts
  always_comb begin
    if (tcount_r == '0) kact = KCNT_W'(1);
    else if (32'(tcount_r) > 32'(MAX_TOPICS)) kact = KCNT_W'(MAX_TOPICS);
    else kact = KCNT_W'(tcount_r);
    if (vcount_r == '0) vact = (VCFG_W+1)'(1);
    else if (32'(vcount_r) > 32'(MAX_VOCAB)) vact = (VCFG_W+1)'(MAX_VOCAB);
    else vact = (VCFG_W+1)'(vcount_r);
  end

  assign uses_word = (in_opcode == OP_LOAD_MODEL) || (in_opcode == OP_SAMPLE) ||
                     (in_opcode == OP_READ_MODEL);
  assign bad_idx = (32'(in_topic_in) >= 32'(kact)) ||
                   (uses_word && (32'(in_word_id) >= 32'(vact)));

  assign in_full  = q_full | clearing;
  assign cmd_push = in_push & ~in_full;

  always_comb begin
    cmd.word  = WORD_W'(in_word_id);
    cmd.topic = TOPIC_W'(in_topic_in);
    cmd.value = in_load_value;
    cmd.rnd   = in_random_frac;
    cmd.kact  = kact;
    if (in_opcode > OP_READ_MODEL) cmd.kind = CK_NOP;
    else if (bad_idx) cmd.kind = CK_ERR;
    else begin
      case (in_opcode)
        OP_LOAD_MODEL: cmd.kind = CK_LOAD_MODEL;
        OP_LOAD_DOC:   cmd.kind = CK_LOAD_DOC;
        OP_SAMPLE:     cmd.kind = CK_SAMPLE;
        OP_READ_DOC:   cmd.kind = CK_READ_DOC;
        OP_READ_MODEL: cmd.kind = CK_READ_MODEL;
        default:       cmd.kind = CK_NOP;
      endcase
    end
  end

  assign cfg.alpha = (alpha_r == '0) ? Q_W'(1) : alpha_r;
  assign cfg.beta  = (beta_r == '0) ? Q_W'(1) : beta_r;
  assign cfg.train = train_r;

endmodule

@@ sv/lgs_cmd_q.sv @@
// Two-entry command queue between the front end and the back end.
// Depends on lgs_pkg for cmd_t.
module lgs_cmd_q (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  lgs_pkg::cmd_t din,
  input  logic          pop,
  output lgs_pkg::cmd_t dout,
  output logic          full,
  output logic          empty
);
  import lgs_pkg::*;

  cmd_t       ent_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  logic       do_push, do_pop;

  assign full    = (cnt_r == 2'd2);
  assign empty   = (cnt_r == 2'd0);
  assign do_push = push & ~full;
  assign do_pop  = pop & ~empty;
  assign dout    = ent_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (do_push) wp_r <= ~wp_r;
      if (do_pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, do_push} - {1'b0, do_pop};
    end
    if (do_push) ent_r[wp_r] <= din;
  end

endmodule

@@ sv/lgs_res_q.sv @@
// Two-entry result queue in front of the result ports.
// Depends on lgs_pkg for res_t.
module lgs_res_q (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  lgs_pkg::res_t din,
  input  logic          pop,
  output lgs_pkg::res_t dout,
  output logic          full,
  output logic          empty
);
  import lgs_pkg::*;

  res_t       ent_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  logic       do_push, do_pop;

  assign full    = (cnt_r == 2'd2);
  assign empty   = (cnt_r == 2'd0);
  assign do_push = push & ~full;
  assign do_pop  = pop & ~empty;
  assign dout    = ent_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (do_push) wp_r <= ~wp_r;
      if (do_pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, do_push} - {1'b0, do_pop};
    end
    if (do_push) ent_r[wp_r] <= din;
  end

endmodule

@@ sv/lgs_div.sv @@
// Restoring divider, one quotient bit per cycle, saturating 64-bit quotient.
// Stand-alone; used by lgs_back for the topic weights.
module lgs_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [47:0] n_hi,
  input  logic [63:0] n_lo,
  input  logic [64:0] den,
  output logic        done,
  output logic [63:0] quo
);

  logic [64:0] rem_r, den_r;
  logic [63:0] nlo_r, quo_r;
  logic [6:0]  cnt_r;
  logic        busy_r, done_r;
  logic [65:0] sh, diff;
  logic        ge;

  assign sh   = {rem_r, nlo_r[63]};
  assign diff = sh - {1'b0, den_r};
  assign ge   = (sh >= {1'b0, den_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        // quotient would not fit in 64 bits: saturate
        if ({17'b0, n_hi} >= den) begin
          quo_r  <= '1;
          done_r <= 1'b1;
        end else begin
          rem_r  <= {17'b0, n_hi};
          nlo_r  <= n_lo;
          den_r  <= den;
          quo_r  <= '0;
          cnt_r  <= 7'd64;
          busy_r <= 1'b1;
        end
      end else if (busy_r) begin
        rem_r <= ge ? diff[64:0] : sh[64:0];
        nlo_r <= {nlo_r[62:0], 1'b0};
        quo_r <= {quo_r[62:0], ge};
        cnt_r <= cnt_r - 7'd1;
        if (cnt_r == 7'd1) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign quo  = quo_r;

endmodule

@@ sv/lgs_back.sv @@
// Back end: count memories, clearing sweep, weight pipeline and topic draw.
// Depends on lgs_pkg and lgs_div; reads lgs_cmd_q, writes lgs_res_q.
module lgs_back (
  input  logic          clk,
  input  logic          rst_n,
  input  lgs_pkg::cfg_t cfg,
  input  logic          cmd_empty,
  input  lgs_pkg::cmd_t cmd,
  output logic          cmd_pop,
  input  logic          res_full,
  output logic          res_push,
  output lgs_pkg::res_t res,
  output logic          clearing
);
  import lgs_pkg::*;

  localparam int WTC_DEPTH = MAX_VOCAB * MAX_TOPICS;

  localparam logic [4:0] S_CLR    = 5'd0;
  localparam logic [4:0] S_IDLE   = 5'd1;
  localparam logic [4:0] S_ISSUE  = 5'd2;
  localparam logic [4:0] S_DATA   = 5'd3;
  localparam logic [4:0] S_DONE   = 5'd4;
  localparam logic [4:0] S_W_RD   = 5'd5;
  localparam logic [4:0] S_W_OPS  = 5'd6;
  localparam logic [4:0] S_W_MUL  = 5'd7;
  localparam logic [4:0] S_W_DIV  = 5'd8;
  localparam logic [4:0] S_W_WAIT = 5'd9;
  localparam logic [4:0] S_W_ACC  = 5'd10;
  localparam logic [4:0] S_T_MUL  = 5'd11;
  localparam logic [4:0] S_S_RD   = 5'd12;
  localparam logic [4:0] S_S_CMP  = 5'd13;
  localparam logic [4:0] S_U_RD1  = 5'd14;
  localparam logic [4:0] S_U_RD2  = 5'd15;
  localparam logic [4:0] S_U_WR1  = 5'd16;
  localparam logic [4:0] S_U_WR2  = 5'd17;

  function automatic logic [COUNT_W-1:0] dec31(input logic [COUNT_W-1:0] v);
    dec31 = (v == '0) ? v : v - COUNT_W'(1);
  endfunction
  function automatic logic [COUNT_W-1:0] inc31(input logic [COUNT_W-1:0] v);
    inc31 = (v == MAX31) ? v : v + COUNT_W'(1);
  endfunction
  function automatic logic [TOT_W-1:0] dec48(input logic [TOT_W-1:0] v);
    dec48 = (v == '0) ? v : v - TOT_W'(1);
  endfunction
  function automatic logic [TOT_W-1:0] inc48(input logic [TOT_W-1:0] v);
    inc48 = (v == MAX48) ? v : v + TOT_W'(1);
  endfunction

  // memories
  logic [COUNT_W-1:0] wtc_mem  [WTC_DEPTH];
  logic [COUNT_W-1:0] doc_mem  [MAX_TOPICS];
  logic [TOT_W-1:0]   corp_mem [MAX_TOPICS];
  logic               flag_mem [MAX_VOCAB];
  logic [69:0]        run_mem  [MAX_TOPICS];

  logic [COUNT_W-1:0] wtc_rd_r, doc_rd_r;
  logic [TOT_W-1:0]   corp_rd_r;
  logic               flag_rd_r;
  logic [69:0]        run_rd_r;

  logic [WTC_AW-1:0]  wtc_ra, wtc_wa;
  logic [TOPIC_W-1:0] tsel, doc_wa, corp_wa;
  logic [WORD_W-1:0]  flag_wa;
  logic               wtc_we, doc_we, corp_we, flag_we, run_we;
  logic [COUNT_W-1:0] wtc_wd, doc_wd;
  logic [TOT_W-1:0]   corp_wd;
  logic               flag_wd;
  logic [69:0]        run_wd;

  // control and datapath registers
  logic [4:0]         state_r, state_nxt;
  cmd_t               cmd_r;
  logic [WTC_AW-1:0]  clr_r;
  logic [KCNT_W-1:0]  i_r;
  logic [TOPIC_W-1:0] r_r;
  logic [38:0]        kb_r;
  logic [47:0]        a_r, b_r;
  logic [64:0]        d_r;
  logic [101:0]       acc_r;
  logic [55:0]        pp_r;
  logic [1:0]         psh_r;
  logic [2:0]         m_r;
  logic [69:0]        total_r;
  logic [COUNT_W-1:0] doc_tp_r, wtc_tp_r, doc_o_r, wtc_o_r;
  logic [TOT_W-1:0]   corp_tp_r, corp_o_r;
  logic               ok_r;
  res_t               res_r;

  // combinational helpers
  logic               cur, moved, ok_now, last_i, pick;
  logic [COUNT_W-1:0] ndz, nwz;
  logic [TOT_W-1:0]   nz, tot_new;
  logic [48:0]        tot_sum;
  logic [COUNT_W-1:0] tot_gap;
  logic [23:0]        ma;
  logic [31:0]        mb;
  logic [1:0]         msh;
  logic [2:0]         nmul;
  logic [101:0]       pp_sh;
  logic [69:0]        sum_nxt, t_val;
  logic               div_start, div_done;
  logic [63:0]        quo;

  lgs_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .n_hi  (acc_r[95:48]),
    .n_lo  ({acc_r[47:0], 16'b0}),
    .den   (d_r),
    .done  (div_done),
    .quo   (quo)
  );

  assign clearing  = (state_r == S_CLR);
  assign cmd_pop   = (state_r == S_IDLE) && !cmd_empty;
  assign res_push  = (state_r == S_DONE) && !res_full;
  assign res       = res_r;
  assign div_start = (state_r == S_W_DIV);

  assign cur     = (i_r[TOPIC_W-1:0] == cmd_r.topic);
  assign moved   = (r_r != cmd_r.topic);
  assign ok_now  = (wtc_rd_r <= COUNT_CEILING);
  assign last_i  = (i_r + KCNT_W'(1) == cmd_r.kact);
  assign t_val   = acc_r[101:32];
  assign pick    = (t_val < run_rd_r) || last_i;
  assign sum_nxt = total_r + {6'b0, quo};
  assign ndz     = cur ? dec31(doc_rd_r) : doc_rd_r;
  assign nwz     = cur ? dec31(wtc_rd_r) : wtc_rd_r;
  assign nz      = cur ? dec48(corp_rd_r) : corp_rd_r;

  // model load: total moves by new-old, clamped to the 48-bit range
  assign tot_sum = {1'b0, corp_rd_r} - 49'(wtc_rd_r) + 49'(cmd_r.value);
  assign tot_gap = wtc_rd_r - corp_rd_r[COUNT_W-1:0];
  always_comb begin
    if (corp_rd_r >= TOT_W'(wtc_rd_r))
      tot_new = tot_sum[48] ? MAX48 : tot_sum[TOT_W-1:0];
    else if (cmd_r.value > tot_gap)
      tot_new = TOT_W'(cmd_r.value - tot_gap);
    else
      tot_new = '0;
  end

  // shared multiplier operands: 24 x 32 partial products
  always_comb begin
    nmul = (state_r == S_T_MUL) ? 3'd3 : 3'd4;
    if (state_r == S_T_MUL) begin
      mb = cmd_r.rnd;
      case (m_r)
        3'd0:    begin ma = total_r[23:0];            msh = 2'd0; end
        3'd1:    begin ma = total_r[47:24];           msh = 2'd1; end
        default: begin ma = {2'b0, total_r[69:48]};   msh = 2'd2; end
      endcase
    end else begin
      case (m_r)
        3'd0:    begin ma = a_r[23:0];  mb = {8'b0, b_r[23:0]};  msh = 2'd0; end
        3'd1:    begin ma = a_r[23:0];  mb = {8'b0, b_r[47:24]}; msh = 2'd1; end
        3'd2:    begin ma = a_r[47:24]; mb = {8'b0, b_r[23:0]};  msh = 2'd1; end
        default: begin ma = a_r[47:24]; mb = {8'b0, b_r[47:24]}; msh = 2'd2; end
      endcase
    end
    case (psh_r)
      2'd0:    pp_sh = {46'b0, pp_r};
      2'd1:    pp_sh = {22'b0, pp_r, 24'b0};
      default: pp_sh = {pp_r[53:0], 48'b0};
    endcase
  end

  // memory addressing
  always_comb begin
    case (state_r)
      S_W_RD:  tsel = i_r[TOPIC_W-1:0];
      S_U_RD2: tsel = r_r;
      default: tsel = cmd_r.topic;
    endcase
    wtc_ra = {cmd_r.word, tsel};

    wtc_we = 1'b0; wtc_wa = {cmd_r.word, cmd_r.topic}; wtc_wd = cmd_r.value;
    doc_we = 1'b0; doc_wa = cmd_r.topic;               doc_wd = cmd_r.value;
    corp_we = 1'b0; corp_wa = cmd_r.topic;             corp_wd = tot_new;
    flag_we = 1'b0; flag_wa = cmd_r.word;              flag_wd = 1'b1;
    run_we = 1'b0;  run_wd = sum_nxt;
    case (state_r)
      S_CLR: begin
        wtc_we = 1'b1;  wtc_wa = clr_r;                   wtc_wd = '0;
        doc_we = 1'b1;  doc_wa = clr_r[TOPIC_W-1:0];      doc_wd = '0;
        corp_we = 1'b1; corp_wa = clr_r[TOPIC_W-1:0];     corp_wd = '0;
        flag_we = 1'b1; flag_wa = clr_r[WORD_W-1:0];      flag_wd = 1'b0;
      end
      S_DATA: begin
        wtc_we  = (cmd_r.kind == CK_LOAD_MODEL);
        corp_we = (cmd_r.kind == CK_LOAD_MODEL);
        doc_we  = (cmd_r.kind == CK_LOAD_DOC);
      end
      S_W_ACC: run_we = 1'b1;
      S_U_WR1: begin
        doc_we  = moved;
        doc_wd  = dec31(doc_tp_r);
        corp_we = moved && cfg.train && ok_now;
        corp_wd = dec48(corp_tp_r);
        wtc_we  = moved && cfg.train && ok_now;
        wtc_wd  = dec31(wtc_tp_r);
        flag_we = cfg.train && !ok_now;
      end
      S_U_WR2: begin
        doc_we  = moved;
        doc_wa  = r_r;
        doc_wd  = inc31(doc_o_r);
        corp_we = moved && cfg.train && ok_r;
        corp_wa = r_r;
        corp_wd = inc48(corp_o_r);
        wtc_we  = moved && cfg.train && ok_r;
        wtc_wa  = {cmd_r.word, r_r};
        wtc_wd  = inc31(wtc_o_r);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wtc_we) wtc_mem[wtc_wa] <= wtc_wd;
    wtc_rd_r <= wtc_mem[wtc_ra];
  end
  always_ff @(posedge clk) begin
    if (doc_we) doc_mem[doc_wa] <= doc_wd;
    doc_rd_r <= doc_mem[tsel];
  end
  always_ff @(posedge clk) begin
    if (corp_we) corp_mem[corp_wa] <= corp_wd;
    corp_rd_r <= corp_mem[tsel];
  end
  always_ff @(posedge clk) begin
    if (flag_we) flag_mem[flag_wa] <= flag_wd;
    flag_rd_r <= flag_mem[cmd_r.word];
  end
  always_ff @(posedge clk) begin
    if (run_we) run_mem[i_r[TOPIC_W-1:0]] <= run_wd;
    run_rd_r <= run_mem[i_r[TOPIC_W-1:0]];
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLR:    if (clr_r == '1) state_nxt = S_IDLE;
      S_IDLE:   if (!cmd_empty) state_nxt = S_ISSUE;
      S_ISSUE:  state_nxt = (cmd_r.kind == CK_SAMPLE) ? S_W_RD : S_DATA;
      S_DATA:   state_nxt = S_DONE;
      S_DONE:   if (!res_full) state_nxt = S_IDLE;
      S_W_RD:   state_nxt = S_W_OPS;
      S_W_OPS:  state_nxt = S_W_MUL;
      S_W_MUL:  if (m_r == nmul) state_nxt = S_W_DIV;
      S_W_DIV:  state_nxt = S_W_WAIT;
      S_W_WAIT: if (div_done) state_nxt = S_W_ACC;
      S_W_ACC:  state_nxt = last_i ? S_T_MUL : S_W_RD;
      S_T_MUL:  if (m_r == nmul) state_nxt = S_S_RD;
      S_S_RD:   state_nxt = S_S_CMP;
      S_S_CMP:  state_nxt = pick ? S_U_RD1 : S_S_RD;
      S_U_RD1:  state_nxt = S_U_RD2;
      S_U_RD2:  state_nxt = S_U_WR1;
      S_U_WR1:  state_nxt = S_U_WR2;
      S_U_WR2:  state_nxt = S_DONE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
      clr_r   <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_CLR) clr_r <= clr_r + WTC_AW'(1);
    end

    case (state_r)
      S_IDLE: cmd_r <= cmd;
      S_ISSUE: begin
        kb_r    <= 39'(cmd_r.kact) * 39'(cfg.beta);
        i_r     <= '0;
        total_r <= '0;
      end
      S_DATA: begin
        case (cmd_r.kind)
          CK_ERR:        res_r <= {IN_TW'(0), COUNT_W'(0), 1'b0, 1'b1};
          CK_LOAD_MODEL: res_r <= {IN_TW'(0), COUNT_W'(0), flag_rd_r, 1'b0};
          CK_READ_DOC:   res_r <= {IN_TW'(0), doc_rd_r, 1'b0, 1'b0};
          CK_READ_MODEL: res_r <= {IN_TW'(0), wtc_rd_r, flag_rd_r, 1'b0};
          default:       res_r <= '0;
        endcase
      end
      S_W_OPS: begin
        a_r   <= 48'({ndz, 16'b0}) + 48'(cfg.alpha);
        b_r   <= 48'({nwz, 16'b0}) + 48'(cfg.beta);
        d_r   <= 65'({nz, 16'b0}) + 65'(kb_r);
        m_r   <= '0;
        acc_r <= '0;
      end
      S_W_MUL, S_T_MUL: begin
        if (m_r < nmul) begin
          pp_r  <= 56'(ma) * 56'(mb);
          psh_r <= msh;
        end
        if (m_r != 3'd0) acc_r <= acc_r + pp_sh;
        m_r <= m_r + 3'd1;
      end
      S_W_ACC: begin
        total_r <= sum_nxt;
        // rewind i for the draw and set up the random product
        if (last_i) begin
          i_r   <= '0;
          m_r   <= '0;
          acc_r <= '0;
        end else begin
          i_r <= i_r + KCNT_W'(1);
        end
      end
      S_S_CMP: begin
        if (pick) r_r <= i_r[TOPIC_W-1:0];
        else i_r <= i_r + KCNT_W'(1);
      end
      S_U_RD2: begin
        doc_tp_r  <= doc_rd_r;
        corp_tp_r <= corp_rd_r;
        wtc_tp_r  <= wtc_rd_r;
      end
      S_U_WR1: begin
        doc_o_r  <= doc_rd_r;
        corp_o_r <= corp_rd_r;
        wtc_o_r  <= wtc_rd_r;
        ok_r     <= ok_now;
        res_r    <= {IN_TW'(r_r), COUNT_W'(0), flag_rd_r | (cfg.train & ~ok_now), 1'b0};
      end
      default: ;
    endcase
  end

endmodule

@@ sv/lda_gibbs_topic_sampler_top.sv @@
// Top level of the LDA collapsed Gibbs topic sampler.
// Depends on lgs_pkg, lgs_front, lgs_cmd_q, lgs_back, lgs_res_q.
//
//   port group | direction | handshake            | payload
//   in_        | input     | push / full          | opcode, word_id, topic_in, load_value,
//              |           |                      | random_frac
//   out_       | output    | empty / pop          | new_topic, read_value, ceiling_hit, status
//   cfg_       | input     | we (no wait)         | index, wdata
//
// Loads, reads and rejected items pass the issue, data and done states in the back end.
// A sample computes a weight for each active topic through the one-bit-per-cycle
// divider, scans the topics in the draw, then updates the counts of the old
// and the new topic.
// After reset the block sweeps all count memories with
// in_full high. A two-deep queue on each side lets input and output stall
// independently of the back end.
module lda_gibbs_topic_sampler_top (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [lgs_pkg::CIDX_W-1:0]  cfg_index,
  input  logic [lgs_pkg::Q_W-1:0]     cfg_wdata,
  input  logic                        in_push,
  output logic                        in_full,
  input  logic [lgs_pkg::OPC_W-1:0]   in_opcode,
  input  logic [lgs_pkg::IN_WW-1:0]   in_word_id,
  input  logic [lgs_pkg::IN_TW-1:0]   in_topic_in,
  input  logic [lgs_pkg::COUNT_W-1:0] in_load_value,
  input  logic [lgs_pkg::Q_W-1:0]     in_random_frac,
  output logic                        out_empty,
  input  logic                        out_pop,
  output logic [lgs_pkg::IN_TW-1:0]   out_new_topic,
  output logic [lgs_pkg::COUNT_W-1:0] out_read_value,
  output logic                        out_ceiling_hit,
  output logic                        out_status
);
  import lgs_pkg::*;

  cmd_t cmd_in, cmd_head;
  cfg_t cfg;
  res_t res_in, res_head;
  logic cmd_push, cmd_pop, cmd_full, cmd_empty;
  logic res_push, res_full, clearing;

  lgs_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .in_push        (in_push),
    .in_opcode      (in_opcode),
    .in_word_id     (in_word_id),
    .in_topic_in    (in_topic_in),
    .in_load_value  (in_load_value),
    .in_random_frac (in_random_frac),
    .q_full         (cmd_full),
    .clearing       (clearing),
    .in_full        (in_full),
    .cmd_push       (cmd_push),
    .cmd            (cmd_in),
    .cfg            (cfg)
  );

  lgs_cmd_q u_cmd_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (cmd_push),
    .din   (cmd_in),
    .pop   (cmd_pop),
    .dout  (cmd_head),
    .full  (cmd_full),
    .empty (cmd_empty)
  );

  lgs_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .cmd_empty (cmd_empty),
    .cmd       (cmd_head),
    .cmd_pop   (cmd_pop),
    .res_full  (res_full),
    .res_push  (res_push),
    .res       (res_in),
    .clearing  (clearing)
  );

  lgs_res_q u_res_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .din   (res_in),
    .pop   (out_pop),
    .dout  (res_head),
    .full  (res_full),
    .empty (out_empty)
  );

  assign out_new_topic   = res_head.new_topic;
  assign out_read_value  = res_head.read_value;
  assign out_ceiling_hit = res_head.ceiling_hit;
  assign out_status      = res_head.status;

endmodule

@@ sv/lgs_checker.sv @@
// Port-level checks for the topic sampler, bound to the top level.
// Depends on lgs_pkg for port widths.
module lgs_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_full,
  input logic                        out_empty,
  input logic                        out_pop,
  input logic [lgs_pkg::IN_TW-1:0]   out_new_topic,
  input logic [lgs_pkg::COUNT_W-1:0] out_read_value,
  input logic                        out_ceiling_hit,
  input logic                        out_status
);

  // reset empties the result side and starts the clearing sweep
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> out_empty)
    else $error("result queue not empty after reset");
  a_reset_full: assert property (@(posedge clk) !rst_n |=> in_full)
    else $error("input taken during memory clearing");

  // an error result carries nothing but the status bit
  a_err_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_status) |->
      (out_new_topic == '0 && out_read_value == '0 && !out_ceiling_hit))
    else $error("error result with nonzero fields");

  // only a sample returns a topic, and a sample returns no count
  a_topic_no_read: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_new_topic != '0) |-> (out_read_value == '0 && !out_status))
    else $error("topic and read value in one result");

  a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=> !out_empty)
    else $error("waiting result dropped");

endmodule

bind lda_gibbs_topic_sampler_top lgs_checker u_lgs_checker (.*);
